// File: rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg - shared constants, types and the sine table of the mapper
// Constellation codes, register indexes, field widths and the quarter-wave
// sine ROM, built at elaboration from a fixed-point Taylor series.
// ----------------------------------------------------------------------------
package gcm_pkg;

  localparam int MAX_BITS     = 8;
  localparam int SINE_ENTRIES = 128;

  localparam int IDX_W   = 8;                          // symbol_index width
  localparam int OUT_W   = 16;                         // Q2.13 output width
  localparam int GAIN_W  = 16;
  localparam int MOD_W   = 2;
  localparam int BPS_W   = 4;
  localparam int WIDX_W  = 2;
  localparam int WDATA_W = 16;

  localparam int BW     = $clog2(MAX_BITS + 1);        // clamped bits per symbol
  localparam int LVL_W  = MAX_BITS + 2;                // signed level M-1-2k
  localparam int PH_W   = $clog2(8 * SINE_ENTRIES);    // phase, below 8 quarter turns
  localparam int AD_W   = $clog2(SINE_ENTRIES + 1);    // ROM address 0..SINE_ENTRIES
  localparam int PSUM_W = MAX_BITS + $clog2(SINE_ENTRIES) + 4;
  localparam int OP_W   = GAIN_W + 1;                  // signed multiplier operand

  localparam logic [MOD_W-1:0] MOD_PAM = 2'd0;
  localparam logic [MOD_W-1:0] MOD_PSK = 2'd1;
  localparam logic [MOD_W-1:0] MOD_QAM = 2'd2;

  localparam logic [WIDX_W-1:0] REG_MODULATION = 2'd0;
  localparam logic [WIDX_W-1:0] REG_BITS       = 2'd1;
  localparam logic [WIDX_W-1:0] REG_GAIN       = 2'd2;

  localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_PAM;
  localparam logic [BPS_W-1:0]  BPS_RESET  = 4'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // control traveling with the operands into the scaler
  typedef struct packed {
    logic valid;
    logic wide;     // PSK product: Q2.30, else level times Q1.15
  } scale_ctl_t;

  typedef logic [SINE_ENTRIES:0][GAIN_W-1:0] sine_rom_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        su;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = (64'(i) * PI_Q30 + 64'(SINE_ENTRIES)) / (2 * SINE_ENTRIES);
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        case (n)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          5: term = term / 110;
          6: term = term / 156;
          default: term = term / 210;
        endcase
        if ((n % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      su = ($unsigned(sum) + (64'd1 << 14)) >> 15;
      if (su > 64'd32768) su = 64'd32768;
      rom[i] = su[GAIN_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: rtl/gcm_scale.sv
// ----------------------------------------------------------------------------
// gcm_scale - gain multiply, rounding and saturation for both axes
// Stage A registers operand times gain; stage B rounds half up to Q2.13
// (shift 2 for levels, 17 for PSK) and saturates to 16 bits.
// ----------------------------------------------------------------------------
module gcm_scale import gcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  scale_ctl_t              ctl,
  input  logic signed [OP_W-1:0]  op_i,
  input  logic signed [OP_W-1:0]  op_q,
  input  logic [GAIN_W-1:0]       gain,
  output logic                    done,
  output logic signed [OUT_W-1:0] in_phase,
  output logic signed [OUT_W-1:0] quadrature
);

  localparam int PROD_W = 2 * OP_W;

  scale_ctl_t                prod_ctl;
  logic signed [PROD_W-1:0]  prod_i;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [OP_W-1:0]    gain_s;

  assign gain_s = $signed({1'b0, gain});

  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p,
    input logic                     wide
  );
    logic signed [PROD_W:0] sum;
    logic signed [PROD_W:0] sh;
    logic signed [OUT_W-1:0] r;
    if (wide) begin
      sum = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(1) <<< 16);
      sh  = sum >>> 17;
    end else begin
      sum = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(2));
      sh  = sum >>> 2;
    end
    if (sh > $signed((PROD_W+1)'(32767))) r = 16'sh7fff;
    else if (sh < -$signed((PROD_W+1)'(32768))) r = 16'sh8000;
    else r = sh[OUT_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
      done     <= 1'b0;
    end else begin
      prod_ctl <= ctl;
      done     <= prod_ctl.valid;
    end
    prod_i     <= op_i * gain_s;
    prod_q     <= op_q * gain_s;
    in_phase   <= round_sat(prod_i, prod_ctl.wide);
    quadrature <= round_sat(prod_q, prod_ctl.wide);
  end

endmodule

// File: rtl/gray_constellation_mapper.sv
// ----------------------------------------------------------------------------
// gray_constellation_mapper - Gray-coded PAM / PSK / QAM symbol mapper
// Decodes the symbol index, forms levels or a sine ROM phase, scales by
// the gain register and delivers one saturated Q2.13 point per item.
// ----------------------------------------------------------------------------
// An accepted item passes the s1, s2 and s3 registers, then the scaler's product and done registers.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// Stages: decode, phase fold, sine ROM and operand select, multiply, round.
// Reset (rst, synchronous): pipeline valid bits cleared; modulation PAM,
// bits_per_symbol 1, gain 32768.
module gray_constellation_mapper import gcm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [IDX_W-1:0]        symbol_index,
  input  logic                    wr_en,
  input  logic [WIDX_W-1:0]       wr_index,
  input  logic [WDATA_W-1:0]      wr_data,
  output logic                    done,
  output logic signed [OUT_W-1:0] in_phase,
  output logic signed [OUT_W-1:0] quadrature
);

  typedef struct packed {
    logic [AD_W-1:0] addr;
    logic            neg;
  } rom_sel_t;

  logic [MOD_W-1:0]  modulation;
  logic [BPS_W-1:0]  bits_per_symbol;
  logic [GAIN_W-1:0] gain;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      modulation      <= MOD_RESET;
      bits_per_symbol <= BPS_RESET;
      gain            <= GAIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_MODULATION: modulation      <= wr_data[MOD_W-1:0];
        REG_BITS:       bits_per_symbol <= wr_data[BPS_W-1:0];
        REG_GAIN:       gain            <= wr_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  function automatic logic [MAX_BITS-1:0] gray_dec(input logic [MAX_BITS-1:0] g);
    logic [MAX_BITS-1:0] k;
    for (int i = 0; i < MAX_BITS; i++) k[i] = ^(g >> i);
    return k;
  endfunction

  // fold a phase in quarter-wave steps to ROM address and sign
  function automatic rom_sel_t fold(input logic [PH_W-1:0] p);
    rom_sel_t r;
    if (p < PH_W'(SINE_ENTRIES)) begin
      r.addr = AD_W'(p);
      r.neg  = 1'b0;
    end else if (p < PH_W'(2 * SINE_ENTRIES)) begin
      r.addr = AD_W'(PH_W'(2 * SINE_ENTRIES) - p);
      r.neg  = 1'b0;
    end else if (p < PH_W'(3 * SINE_ENTRIES)) begin
      r.addr = AD_W'(p - PH_W'(2 * SINE_ENTRIES));
      r.neg  = 1'b1;
    end else begin
      r.addr = AD_W'(PH_W'(4 * SINE_ENTRIES) - p);
      r.neg  = 1'b1;
    end
    return r;
  endfunction

  // ---------------- stage 0: decode ----------------
  logic [BW-1:0]           b_eff;
  logic [BW-1:0]           lb;
  logic [BW-1:0]           hb;
  logic [MAX_BITS:0]       m;
  logic [MAX_BITS-1:0]     s;
  logic [MAX_BITS-1:0]     k;
  logic [MAX_BITS-1:0]     lo_k;
  logic [MAX_BITS-1:0]     hi_k;
  logic [LVL_W-1:0]        pam_lvl;
  logic [LVL_W-1:0]        qam_lvl_i;
  logic [LVL_W-1:0]        qam_lvl_q;
  logic [LVL_W-1:0]        lvl_i_next;
  logic [LVL_W-1:0]        lvl_q_next;
  logic [PSUM_W-1:0]       psum;
  logic [PH_W-1:0]         phase_next;

  always_comb begin
    if (bits_per_symbol == '0) b_eff = BW'(1);
    else if (bits_per_symbol > BPS_W'(MAX_BITS)) b_eff = BW'(MAX_BITS);
    else b_eff = BW'(bits_per_symbol);
    lb = b_eff >> 1;
    hb = b_eff - lb;
    m  = (MAX_BITS+1)'(1) << b_eff;
    s  = MAX_BITS'(symbol_index) & MAX_BITS'(m - (MAX_BITS+1)'(1));
    k  = gray_dec(s);
    lo_k = gray_dec(s & MAX_BITS'(((MAX_BITS+1)'(1) << lb) - (MAX_BITS+1)'(1)));
    hi_k = gray_dec(s >> lb);
    pam_lvl   = LVL_W'(m) - LVL_W'(1) - (LVL_W'(k) << 1);
    qam_lvl_i = (LVL_W'(1) << hb) - LVL_W'(1) - (LVL_W'(hi_k) << 1);
    qam_lvl_q = (LVL_W'(1) << lb) - LVL_W'(1) - (LVL_W'(lo_k) << 1);
    psum = ((PSUM_W'(k) << 1) + PSUM_W'(1)) * PSUM_W'(2 * SINE_ENTRIES)
           + PSUM_W'(m >> 1);
    phase_next = PH_W'(psum >> b_eff);
    case (modulation)
      MOD_PAM: begin
        lvl_i_next = pam_lvl;
        lvl_q_next = '0;
      end
      MOD_QAM: begin
        lvl_i_next = qam_lvl_i;
        lvl_q_next = qam_lvl_q;
      end
      default: begin
        lvl_i_next = '0;
        lvl_q_next = '0;
      end
    endcase
  end

  logic             s1_valid;
  logic [LVL_W-1:0] s1_lvl_i;
  logic [LVL_W-1:0] s1_lvl_q;
  logic [PH_W-1:0]  s1_phase;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start && !busy;
    s1_lvl_i <= lvl_i_next;
    s1_lvl_q <= lvl_q_next;
    s1_phase <= phase_next;
  end

  // ---------------- stage 1: phase fold ----------------
  logic [PH_W-1:0] p_sin;
  logic [PH_W:0]   p_cos_sum;
  logic [PH_W-1:0] p_cos;
  rom_sel_t        sin_sel_next;
  rom_sel_t        cos_sel_next;

  always_comb begin
    if (s1_phase >= PH_W'(4 * SINE_ENTRIES))
      p_sin = s1_phase - PH_W'(4 * SINE_ENTRIES);
    else
      p_sin = s1_phase;
    p_cos_sum = (PH_W+1)'(p_sin) + (PH_W+1)'(SINE_ENTRIES);
    if (p_cos_sum >= (PH_W+1)'(4 * SINE_ENTRIES))
      p_cos = PH_W'(p_cos_sum - (PH_W+1)'(4 * SINE_ENTRIES));
    else
      p_cos = PH_W'(p_cos_sum);
    sin_sel_next = fold(p_sin);
    cos_sel_next = fold(p_cos);
  end

  logic             s2_valid;
  logic [LVL_W-1:0] s2_lvl_i;
  logic [LVL_W-1:0] s2_lvl_q;
  rom_sel_t         s2_sin;
  rom_sel_t         s2_cos;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
    s2_lvl_i <= s1_lvl_i;
    s2_lvl_q <= s1_lvl_q;
    s2_sin   <= sin_sel_next;
    s2_cos   <= cos_sel_next;
  end

  // ---------------- stage 2: sine ROM, operand select ----------------
  logic signed [OP_W-1:0] sin_val;
  logic signed [OP_W-1:0] cos_val;
  logic signed [OP_W-1:0] op_i_next;
  logic signed [OP_W-1:0] op_q_next;
  logic                   psk;

  always_comb begin
    sin_val = $signed({1'b0, SINE_ROM[s2_sin.addr]});
    cos_val = $signed({1'b0, SINE_ROM[s2_cos.addr]});
    if (s2_sin.neg) sin_val = -sin_val;
    if (s2_cos.neg) cos_val = -cos_val;
    psk = (modulation == MOD_PSK);
    if (psk) begin
      op_i_next = cos_val;
      op_q_next = sin_val;
    end else begin
      op_i_next = OP_W'($signed(s2_lvl_i));
      op_q_next = OP_W'($signed(s2_lvl_q));
    end
  end

  scale_ctl_t             s3_ctl;
  logic signed [OP_W-1:0] s3_op_i;
  logic signed [OP_W-1:0] s3_op_q;

  always_ff @(posedge clk) begin
    if (rst) s3_ctl <= '0;
    else begin
      s3_ctl.valid <= s2_valid;
      s3_ctl.wide  <= psk;
    end
    s3_op_i <= op_i_next;
    s3_op_q <= op_q_next;
  end

  // ---------------- stages 3 and 4: multiply, round, saturate ----------------
  gcm_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .ctl        (s3_ctl),
    .op_i       (s3_op_i),
    .op_q       (s3_op_q),
    .gain       (gain),
    .done       (done),
    .in_phase   (in_phase),
    .quadrature (quadrature)
  );

  // ---------------- assertions ----------------
  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted item not delivered after 5 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s3_ctl.valid, 2) && $past(s1_valid, 4))
    else $error("result without an accepted item");

  a_rom_range: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_sin.addr <= AD_W'(SINE_ENTRIES)) &&
                 (s2_cos.addr <= AD_W'(SINE_ENTRIES)))
    else $error("sine ROM address out of range");

endmodule
